// File: src/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/demsa_pkg.sv
// package: constants, codes and control structs of the mark stack allocator
`timescale 1ns / 1ps
package demsa_pkg;
  localparam int MARK_ENTRIES = 32;
  localparam int TAG_BITS     = 16;
  localparam int ADDR_BITS    = 32;
  localparam int IDX_W        = $clog2(MARK_ENTRIES);
  localparam int CNT_W        = $clog2(MARK_ENTRIES + 1);
  localparam int SHORT_W      = 31;

  localparam logic [ADDR_BITS-1:0] ARENA_RESET = ADDR_BITS'(32'h8000_0000);
  localparam logic [SHORT_W-1:0]   SHORT_MAX   = {SHORT_W{1'b1}};

  localparam logic [2:0] CMD_OPEN  = 3'd0;
  localparam logic [2:0] CMD_CLOSE = 3'd1;
  localparam logic [2:0] CMD_ALLOC = 3'd2;
  localparam logic [2:0] CMD_FREE  = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_SEQ      = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_HOLE     = 3'd6;

  typedef struct packed {
    logic load;
    logic exec;
    logic alloc2;
    logic scan;
    logic coll;
    logic coll_fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic alloc_go;
    logic free_go;
    logic hit;
    logic hit_top;
    logic scan_last;
    logic coll_stop;
  } dp_stat_t;
endpackage

// File: src/demsa_ctrl.sv
// controller: sequences one transaction at a time and owns the handshakes
`timescale 1ns / 1ps
module demsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output demsa_pkg::dp_cmd_t  cmd_o,
  input  demsa_pkg::dp_stat_t stat_i
);
  import demsa_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_ALLOC2   = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_COLL     = 3'd4;
  localparam logic [2:0] S_COLL_FIN = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.alloc_go) state_d = S_ALLOC2;
        else if (stat_i.free_go) state_d = S_SCAN;
        else state_d = S_OUT;
      end
      S_ALLOC2: begin
        cmd_o.alloc2 = 1'b1;
        state_d      = S_OUT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) state_d = stat_i.hit_top ? S_COLL : S_OUT;
        else if (stat_i.scan_last) state_d = S_OUT;
      end
      S_COLL: begin
        cmd_o.coll = 1'b1;
        if (stat_i.coll_stop) state_d = S_COLL_FIN;
      end
      S_COLL_FIN: begin
        cmd_o.coll_fin = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// File: src/demsa_dp.sv
// datapath: side pointers, mark stacks, allocation arithmetic and result registers
`timescale 1ns / 1ps
module demsa_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [31:0]                          cfg_wdata_i,
  input  logic [2:0]                           cmd_i,
  input  logic                                 side_i,
  input  logic [15:0]                          tag_i,
  input  logic [31:0]                          size_i,
  input  logic [31:0]                          alignment_i,
  input  demsa_pkg::dp_cmd_t                   ctl_i,
  output demsa_pkg::dp_stat_t                  stat_o,
  output logic [2:0]                           status_o,
  output logic [31:0]                          address_o,
  output logic [30:0]                          shortage_o,
  output logic [31:0]                          free_bytes_o
);
  import demsa_pkg::*;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [ADDR_BITS-1:0] start;
  } mark_t;

  localparam int MEM_DEPTH = 2 * (1 << IDX_W);

  // control state
  logic [ADDR_BITS-1:0] ptr_q [2];
  logic [CNT_W-1:0]     count_q [2];
  logic [1:0]           open_q;
  logic [1:0][MARK_ENTRIES-1:0] live_q;
  logic [SHORT_W-1:0]   short_q;

  // payload
  logic [TAG_BITS-1:0]  open_tag_q [2];
  logic [2:0]           cmd_q;
  logic                 side_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [31:0]          size_q, align_q;
  logic [IDX_W-1:0]     idx_q;
  logic [32:0]          a_start_q;
  logic                 a_over_q;
  logic [2:0]           res_st_q;
  logic [31:0]          res_addr_q;
  logic [2:0]           status_q;
  logic [31:0]          address_q, free_q;
  logic [SHORT_W-1:0]   short_out_q;

  mark_t                mem [MEM_DEPTH];
  mark_t                rdata_q;
  logic [IDX_W:0]       raddr;

  logic [31:0]          mask, low, high, hdiff;
  logic                 bad_args, pow2;
  logic [33:0]          end_w, short_w;
  logic [SHORT_W-1:0]   short_sat;
  logic                 live_here, live_below;

  assign mask       = align_q - 32'd1;
  assign pow2       = (align_q & mask) == 32'd0;
  assign bad_args   = (size_q == 32'd0) || (align_q == 32'd0) || !pow2;
  assign low        = 32'(ptr_q[0]);
  assign high       = 32'(ptr_q[1]);
  assign hdiff      = high - size_q;
  assign live_here  = live_q[side_q][idx_q];
  assign live_below = (idx_q != '0) && live_q[side_q][idx_q - IDX_W'(1)];

  // status towards the controller
  always_comb begin
    stat_o           = '0;
    stat_o.alloc_go  = (cmd_q == CMD_ALLOC) && !bad_args && open_q[side_q];
    stat_o.free_go   = (cmd_q == CMD_FREE) && !open_q[side_q] && (count_q[side_q] != '0);
    stat_o.hit       = live_here && (rdata_q.tag == tag_q);
    stat_o.hit_top   = (CNT_W'(idx_q) + CNT_W'(1)) == count_q[side_q];
    stat_o.scan_last = stat_o.hit_top;
    stat_o.coll_stop = (idx_q == '0) || live_below;
  end

  // second allocation step: end point and shortage
  always_comb begin
    end_w   = {1'b0, a_start_q} + {2'b0, size_q};
    short_w = '0;
    if (!side_q) begin
      if (end_w > {2'b0, high}) short_w = end_w - {2'b0, high};
    end else if (a_over_q) begin
      short_w = {2'b0, size_q} - {2'b0, high} + {2'b0, low};
    end else if (a_start_q[31:0] < low) begin
      short_w = {2'b0, low} - {2'b0, a_start_q[31:0]};
    end
    short_sat = (short_w[33:SHORT_W] != '0) ? SHORT_MAX : short_w[SHORT_W-1:0];
  end

  // mark memory read address
  always_comb begin
    if (ctl_i.exec) raddr = {side_q, {IDX_W{1'b0}}};
    else if (ctl_i.scan) raddr = {side_q, idx_q + IDX_W'(1)};
    else raddr = {side_q, idx_q};
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (ctl_i.exec && cmd_q == CMD_OPEN && !open_q[side_q] &&
        count_q[side_q] != CNT_W'(MARK_ENTRIES)) begin
      mem[{side_q, count_q[side_q][IDX_W-1:0]}] <= '{tag: tag_q, start: ptr_q[side_q]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q[0]   <= '0;
      ptr_q[1]   <= ARENA_RESET;
      count_q[0] <= '0;
      count_q[1] <= '0;
      open_q     <= '0;
      live_q     <= '0;
      short_q    <= '0;
    end else if (cfg_we_i) begin
      ptr_q[0]   <= '0;
      ptr_q[1]   <= ADDR_BITS'(cfg_wdata_i);
      count_q[0] <= '0;
      count_q[1] <= '0;
      open_q     <= '0;
      live_q     <= '0;
      short_q    <= '0;
    end else begin
      if (ctl_i.exec) begin
        case (cmd_q)
          CMD_OPEN: begin
            if (!open_q[side_q] && count_q[side_q] != CNT_W'(MARK_ENTRIES)) begin
              live_q[side_q][count_q[side_q][IDX_W-1:0]] <= 1'b1;
              count_q[side_q] <= count_q[side_q] + CNT_W'(1);
              open_q[side_q]  <= 1'b1;
            end
          end
          CMD_CLOSE: begin
            if (open_q[side_q] && open_tag_q[side_q] == tag_q) open_q[side_q] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (ctl_i.alloc2) begin
        short_q <= short_sat;
        if (short_w == '0) ptr_q[side_q] <= side_q ? a_start_q[31:0] : end_w[31:0];
      end
      if (ctl_i.scan && stat_o.hit) live_q[side_q][idx_q] <= 1'b0;
      if (ctl_i.coll_fin) begin
        ptr_q[side_q]   <= rdata_q.start;
        count_q[side_q] <= CNT_W'(idx_q);
      end
    end
  end

  // item registers and working values
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= cmd_i;
      side_q  <= side_i;
      tag_q   <= TAG_BITS'(tag_i);
      size_q  <= size_i;
      align_q <= alignment_i;
    end
    if (ctl_i.exec) begin
      res_addr_q <= '0;
      idx_q      <= '0;
      if (side_q) a_start_q <= {1'b0, hdiff & ~mask};
      else a_start_q <= ({1'b0, low} + {1'b0, mask}) & {1'b1, ~mask};
      a_over_q <= size_q > high;
      case (cmd_q)
        CMD_OPEN: begin
          if (open_q[side_q]) res_st_q <= ST_SEQ;
          else if (count_q[side_q] == CNT_W'(MARK_ENTRIES)) res_st_q <= ST_FULL;
          else begin
            res_st_q           <= ST_OK;
            open_tag_q[side_q] <= tag_q;
          end
        end
        CMD_CLOSE: begin
          if (open_q[side_q] && open_tag_q[side_q] == tag_q) res_st_q <= ST_OK;
          else res_st_q <= ST_SEQ;
        end
        CMD_ALLOC: begin
          if (bad_args) res_st_q <= ST_INVALID;
          else if (!open_q[side_q]) res_st_q <= ST_SEQ;
          else res_st_q <= ST_OK;
        end
        CMD_FREE: begin
          if (open_q[side_q]) res_st_q <= ST_SEQ;
          else res_st_q <= ST_NOTFOUND;
        end
        CMD_QUERY: res_st_q <= ST_OK;
        default:   res_st_q <= ST_INVALID;
      endcase
    end
    if (ctl_i.alloc2) begin
      if (short_w == '0) begin
        res_st_q   <= ST_OK;
        res_addr_q <= a_start_q[31:0];
      end else begin
        res_st_q <= ST_NOSPACE;
      end
    end
    if (ctl_i.scan) begin
      if (stat_o.hit) res_st_q <= stat_o.hit_top ? ST_OK : ST_HOLE;
      else idx_q <= idx_q + IDX_W'(1);
    end
    if (ctl_i.coll && !stat_o.coll_stop) idx_q <= idx_q - IDX_W'(1);
    if (ctl_i.emit) begin
      status_q    <= res_st_q;
      address_q   <= res_addr_q;
      short_out_q <= short_q;
      free_q      <= 32'(ptr_q[1] - ptr_q[0]);
    end
  end

  assign status_o     = status_q;
  assign address_o    = address_q;
  assign shortage_o   = short_out_q;
  assign free_bytes_o = free_q;
endmodule

// File: src/double_ended_mark_stack_allocator.sv
// top level: two-ended mark stack allocator over one arena
//
//  port group   direction  handshake            payload
//  in           in         in_valid_i/in_stall_o  cmd, side, tag, size, alignment
//  out          out        out_valid_o/out_stall_i status, address, shortage, free_bytes
//  cfg          in         cfg_we_i             cfg_wdata_i (arena size)
//
// open, close, query: load, execute, result registered; allocate adds an end-point step
// free: execute, scan up from the bottom mark, and a collapse when the top mark goes; the
//   single read port of the mark memory walks one entry a cycle
// one transaction at a time; a new one is taken once the result is registered
// reset or a cfg write resets pointers and clears marks and shortage; out stall holds the result
`timescale 1ns / 1ps
module double_ended_mark_stack_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic        side_i,
  input  logic [15:0] tag_i,
  input  logic [31:0] size_i,
  input  logic [31:0] alignment_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] address_o,
  output logic [30:0] shortage_o,
  output logic [31:0] free_bytes_o
);
  import demsa_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  demsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctl),
    .stat_i      (stat)
  );

  demsa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd_i),
    .side_i       (side_i),
    .tag_i        (tag_i),
    .size_i       (size_i),
    .alignment_i  (alignment_i),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .status_o     (status_o),
    .address_o    (address_o),
    .shortage_o   (shortage_o),
    .free_bytes_o (free_bytes_o)
  );
endmodule

// File: src/demsa_chk.sv
// port checker for the allocator and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module demsa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] address_o,
  input logic [30:0] shortage_o
);
  import demsa_pkg::*;

  `AST_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `AST_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `AST_NOW(a_nospace_short, out_valid_o && status_o == ST_NOSPACE, shortage_o != '0)
  `AST_NOW(a_fail_no_addr, out_valid_o && status_o != ST_OK, address_o == '0)
endmodule

bind double_ended_mark_stack_allocator demsa_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .address_o   (address_o),
  .shortage_o  (shortage_o)
);

// File: sim/tb_double_ended_mark_stack_allocator.sv
// testbench: directed table and random mark/alloc/free traffic checked against a predictor
`timescale 1ns / 1ps
module tb_double_ended_mark_stack_allocator;
  import demsa_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [2:0]  cmd;
    logic        side;
    logic [15:0] tag;
    logic [31:0] size;
    logic [31:0] align;
    logic        chk;
    logic [2:0]  st;
  } alloc_op_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] address;
    logic [30:0] shortage;
    logic [31:0] free_bytes;
  } alloc_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic        side_i = 1'b0;
  logic [15:0] tag_i = '0;
  logic [31:0] size_i = '0;
  logic [31:0] alignment_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] address_o;
  logic [30:0] shortage_o;
  logic [31:0] free_bytes_o;

  double_ended_mark_stack_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .cmd_i, .side_i, .tag_i, .size_i, .alignment_i,
    .out_valid_o, .out_stall_i, .status_o, .address_o, .shortage_o, .free_bytes_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // allocator state as predicted
  longint unsigned arena_bytes;
  longint unsigned side_ptr [2];
  logic [15:0]     stk_tag [2][MARK_ENTRIES];
  longint unsigned stk_start [2][MARK_ENTRIES];
  bit              stk_live [2][MARK_ENTRIES];
  int              stk_depth [2];
  logic [15:0]     cur_tag [2];
  bit              cur_open [2];
  longint unsigned shortage_kept;

  alloc_res_t expected_results [$];
  int  errors = 0;
  int  accepted = 0;
  int  checked = 0;
  int  hold_req = 0;
  int  burst_left = 0;
  bit  valid_hi = 1'b0;
  int  status_seen [8];
  longint cycles = 0;

  function automatic void clear_allocator();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < MARK_ENTRIES; i++) stk_live[s][i] = 1'b0;
      stk_depth[s] = 0;
      cur_open[s] = 1'b0;
    end
    side_ptr[0] = 0;
    side_ptr[1] = arena_bytes;
    shortage_kept = 0;
  endfunction

  function automatic logic [2:0] predict_alloc(bit s, longint unsigned sz, longint unsigned al,
                                               ref longint unsigned addr);
    longint unsigned mask, lo, hi, start, stop, short_amt;
    short_amt = 0;
    if (sz == 0 || al == 0 || (al & (al - 1)) != 0) return ST_INVALID;
    if (!cur_open[s]) return ST_SEQ;
    mask = al - 1;
    lo = side_ptr[0];
    hi = side_ptr[1];
    start = 0;
    stop = 0;
    if (s) begin
      if (sz > hi) short_amt = sz - hi + lo;
      else begin
        start = (hi - sz) & ~mask;
        if (start < lo) short_amt = lo - start;
      end
    end else begin
      start = (lo + mask) & ~mask;
      stop = start + sz;
      if (stop > hi) short_amt = stop - hi;
    end
    shortage_kept = short_amt > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : short_amt;
    if (short_amt != 0) return ST_NOSPACE;
    side_ptr[s] = (s ? start : stop) & 64'hFFFF_FFFF;
    addr = start & 64'hFFFF_FFFF;
    return ST_OK;
  endfunction

  function automatic logic [2:0] predict_free(bit s, logic [15:0] t);
    int i;
    if (cur_open[s]) return ST_SEQ;
    for (i = 0; i < stk_depth[s]; i++)
      if (stk_live[s][i] && stk_tag[s][i] == t) break;
    if (i >= stk_depth[s]) return ST_NOTFOUND;
    stk_live[s][i] = 1'b0;
    if (i + 1 != stk_depth[s]) return ST_HOLE;
    // unwind through marks already released below the top
    do begin
      side_ptr[s] = stk_start[s][stk_depth[s] - 1];
      stk_depth[s]--;
    end while (stk_depth[s] != 0 && !stk_live[s][stk_depth[s] - 1]);
    return ST_OK;
  endfunction

  function automatic alloc_res_t predict_allocator(alloc_op_t o);
    alloc_res_t r;
    longint unsigned addr;
    bit s;
    addr = 0;
    s = o.side;
    case (o.cmd)
      CMD_OPEN: begin
        if (cur_open[s]) r.status = ST_SEQ;
        else if (stk_depth[s] >= MARK_ENTRIES) r.status = ST_FULL;
        else begin
          stk_tag[s][stk_depth[s]] = o.tag;
          stk_start[s][stk_depth[s]] = side_ptr[s];
          stk_live[s][stk_depth[s]] = 1'b1;
          stk_depth[s]++;
          cur_tag[s] = o.tag;
          cur_open[s] = 1'b1;
          r.status = ST_OK;
        end
      end
      CMD_CLOSE: begin
        if (!cur_open[s] || cur_tag[s] != o.tag) r.status = ST_SEQ;
        else begin
          cur_open[s] = 1'b0;
          r.status = ST_OK;
        end
      end
      CMD_ALLOC: r.status = predict_alloc(s, o.size, o.align, addr);
      CMD_FREE:  r.status = predict_free(s, o.tag);
      CMD_QUERY: r.status = ST_OK;
      default:   r.status = ST_INVALID;
    endcase
    r.address = addr[31:0];
    r.shortage = shortage_kept[30:0];
    r.free_bytes = 32'(side_ptr[1] - side_ptr[0]);
    return r;
  endfunction

  task automatic send_op(alloc_op_t o);
    alloc_res_t r;
    in_valid_i  <= 1'b1;
    valid_hi = 1'b1;
    cmd_i       <= o.cmd;
    side_i      <= o.side;
    tag_i       <= o.tag;
    size_i      <= o.size;
    alignment_i <= o.align;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_allocator(o);
    if (o.chk) r.status = o.st;
    expected_results.push_back(r);
    accepted++;
    if (burst_left > 0) burst_left--;
    else begin
      in_valid_i <= 1'b0;
      valid_hi = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  task automatic wait_drained();
    if (valid_hi) begin
      in_valid_i <= 1'b0;
      valid_hi = 1'b0;
      @(posedge clk_i);
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_arena(logic [31:0] bytes);
    wait_drained();
    repeat (80) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bytes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    arena_bytes = bytes;
    clear_allocator();
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return $urandom | 32'd1;
      1, 2:    return $urandom_range(1, 1 << 20);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic logic [31:0] pick_align();
    if ($urandom_range(0, 9) == 0) return 32'd1 << $urandom_range(0, 31);
    return 32'd1 << $urandom_range(0, 6);
  endfunction

  function automatic alloc_op_t mk(logic [2:0] c, bit s, logic [15:0] t,
                                   logic [31:0] sz = 0, logic [31:0] al = 0);
    alloc_op_t o;
    o.cmd = c; o.side = s; o.tag = t; o.size = sz; o.align = al;
    o.chk = 1'b0; o.st = ST_OK;
    return o;
  endfunction

  // one well-formed mark: open, a few allocations, close; sometimes a free instead
  task automatic run_mark_sequence();
    bit s;
    logic [15:0] t;
    int k;
    s = 1'($urandom_range(0, 1));
    t = 16'($urandom);
    if (stk_depth[s] >= MARK_ENTRIES - 2 || ($urandom_range(0, 2) == 0 && stk_depth[s] > 0)) begin
      k = $urandom_range(0, stk_depth[s] - 1);
      if ($urandom_range(0, 2) != 0) k = stk_depth[s] - 1;
      send_op(mk(CMD_FREE, s, stk_tag[s][k]));
      return;
    end
    send_op(mk(CMD_OPEN, s, t));
    repeat ($urandom_range(0, 3)) send_op(mk(CMD_ALLOC, s, t, pick_size(), pick_align()));
    send_op(mk(CMD_CLOSE, s, t));
  endtask

  task automatic run_random(int n);
    alloc_op_t o;
    int start;
    start = accepted;
    while (accepted - start < n) begin
      if ($urandom_range(0, 6) == 0) begin
        o = mk(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 16'($urandom), $urandom,
               ($urandom_range(0, 1) ? $urandom : pick_align()));
        send_op(o);
      end else run_mark_sequence();
    end
  endtask

  // directed table; typed-in status where it is plain from the spec
  alloc_op_t directed [$];
  task automatic add_row(alloc_op_t o, bit chk, logic [2:0] st);
    o.chk = chk;
    o.st = st;
    directed.push_back(o);
  endtask

  initial begin
    add_row(mk(CMD_QUERY, 0, 16'h0000), 1, ST_OK);
    add_row(mk(CMD_ALLOC, 0, 16'h0000, 32'd8, 32'd1), 1, ST_SEQ);
    add_row(mk(3'd7, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, ST_INVALID);
    add_row(mk(CMD_OPEN, 0, 16'h0000), 1, ST_OK);
    add_row(mk(CMD_OPEN, 0, 16'h0005), 1, ST_SEQ);
    add_row(mk(CMD_ALLOC, 0, 16'h0000, 32'd0, 32'd1), 1, ST_INVALID);
    add_row(mk(CMD_ALLOC, 0, 16'h0000, 32'd10, 32'd3), 1, ST_INVALID);
    add_row(mk(CMD_ALLOC, 0, 16'h0000, 32'd1, 32'd0), 1, ST_INVALID);
    add_row(mk(CMD_ALLOC, 0, 16'h0000, 32'hFFFF_FFFF, 32'd1), 1, ST_NOSPACE);
    add_row(mk(CMD_ALLOC, 0, 16'h0000, 32'd100, 32'h8000_0000), 0, ST_OK);
    add_row(mk(CMD_ALLOC, 0, 16'h0000, 32'd3, 32'd16), 0, ST_OK);
    add_row(mk(CMD_CLOSE, 0, 16'h0001), 1, ST_SEQ);
    add_row(mk(CMD_CLOSE, 0, 16'h0000), 1, ST_OK);
    add_row(mk(CMD_FREE, 0, 16'h0009), 1, ST_NOTFOUND);
    add_row(mk(CMD_OPEN, 1, 16'hFFFF), 1, ST_OK);
    add_row(mk(CMD_ALLOC, 1, 16'hFFFF, 32'h1000, 32'h10), 0, ST_OK);
    add_row(mk(CMD_ALLOC, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'd1), 1, ST_NOSPACE);
    add_row(mk(CMD_FREE, 1, 16'hFFFF), 1, ST_SEQ);
    add_row(mk(CMD_CLOSE, 1, 16'hFFFF), 1, ST_OK);
    add_row(mk(CMD_OPEN, 1, 16'h0002), 1, ST_OK);
    add_row(mk(CMD_ALLOC, 1, 16'h0002, 32'd77, 32'd4), 0, ST_OK);
    add_row(mk(CMD_CLOSE, 1, 16'h0002), 1, ST_OK);
    add_row(mk(CMD_FREE, 1, 16'hFFFF), 1, ST_HOLE);
    add_row(mk(CMD_FREE, 1, 16'h0002), 0, ST_OK);
    add_row(mk(CMD_FREE, 0, 16'h0000), 0, ST_OK);
    add_row(mk(3'd5, 0, 16'h1234), 1, ST_INVALID);
    add_row(mk(3'd6, 1, 16'h4321), 1, ST_INVALID);
  end

  initial begin
    arena_bytes = ARENA_RESET;
    clear_allocator();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_op(directed[i]);

    // fill the low stack to the table limit, then release it from the bottom
    set_arena(32'hFFFF_FFFF);
    for (int i = 0; i <= MARK_ENTRIES; i++) begin
      send_op(mk(CMD_OPEN, 0, 16'(i)));
      send_op(mk(CMD_CLOSE, 0, 16'(i)));
    end
    for (int i = 0; i < MARK_ENTRIES; i++) send_op(mk(CMD_FREE, 0, 16'(i)));
    run_random(100);

    // receiver holds off while the sender keeps offering
    hold_req = 400;
    run_random(80);
    wait_drained();

    set_arena(32'd1);
    run_random(60);
    set_arena(32'd4096);
    run_random(150);
    set_arena($urandom_range(1, 1 << 24));
    run_random(100);
    set_arena(32'h8000_0000);
    run_random(100);

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("%0d transactions checked over arena sizes 1 to 2^32-1; statuses seen:", checked);
    $display("  ok %0d invalid %0d nospace %0d full %0d seq %0d notfound %0d hole %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("tb_double_ended_mark_stack_allocator: clean");
    end else begin
      $display("tb_double_ended_mark_stack_allocator: errors");
    end
    $finish;
  end

  // receiver stall: patterns picked at random plus a long hold on request
  initial begin
    int mode;
    int phase;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      phase++;
      if (phase % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 1) == 1);
        default: out_stall_i <= (phase % 5 < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    alloc_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: status %0d", status_o);
      end else begin
        e = expected_results.pop_front();
        checked++;
        status_seen[status_o]++;
        if (status_o !== e.status || address_o !== e.address ||
            shortage_o !== e.shortage || free_bytes_o !== e.free_bytes) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: exp st %0d addr %h short %h free %h, got st %0d addr %h short %h free %h",
                     checked, e.status, e.address, e.shortage, e.free_bytes,
                     status_o, address_o, shortage_o, free_bytes_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("tb_double_ended_mark_stack_allocator: errors");
      $finish;
    end
  end
endmodule

// File: sim.f
+incdir+src
src/demsa_pkg.sv
src/demsa_ctrl.sv
src/demsa_dp.sv
src/double_ended_mark_stack_allocator.sv
src/demsa_chk.sv
sim/tb_double_ended_mark_stack_allocator.sv
